[hw/rtl/lbp_pkg.sv]
// Shared types, register codes and sizing helpers for the 3x3 LBP code stream.
// No dependencies; imported by every module of the block.
package lbp_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;

  localparam int unsigned WIDTH_RST  = 640;
  localparam int unsigned HEIGHT_RST = 480;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned COL_W      = 10;
  localparam int unsigned CFG_W      = 13;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_WIDTH_BITS  = 11;
  localparam int unsigned CFG_HEIGHT_BITS = 13;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  // one column of the 3x3 neighborhood
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  // which neighbor rows/columns fall outside the image
  typedef struct packed {
    logic top;
    logic bot;
    logic left;
    logic right;
  } border_t;

  typedef struct packed {
    logic    take;   // word enters the datapath
    logic    emit;   // word produces a code
    logic    write;  // word is a pixel stored in the line buffers
    logic    fix;    // single-row frame: center column comes from the held first pixel
    border_t border;
  } item_t;

  // clamp a programmed dimension to [1, mx]
  function automatic int unsigned sat_dim(input int unsigned v, input int unsigned mx);
    int unsigned r;
    r = v;
    if (v == 0) r = 1;
    else if (v > mx) r = mx;
    return r;
  endfunction

endpackage

[hw/rtl/lbp_ctrl.sv]
// Config registers, raster position counters and per-word decode.
// Depends on lbp_pkg.
module lbp_ctrl #(
  parameter int unsigned MAX_WIDTH  = lbp_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = lbp_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lbp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lbp_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              accept_i,
  input  logic                              kind_i,
  input  lbp_pkg::pix_t                     pixel_i,
  output lbp_pkg::item_t                    item_o,
  output lbp_pkg::pix_t                     pix_o,
  output logic [$clog2(MAX_WIDTH)-1:0]      addr_o,
  output logic [$clog2(MAX_WIDTH)-1:0]      em_col_o,
  output logic [$clog2(MAX_HEIGHT)-1:0]     em_row_o
);
  import lbp_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned W_RST = sat_dim(WIDTH_RST, MAX_WIDTH);
  localparam int unsigned H_RST = sat_dim(HEIGHT_RST, MAX_HEIGHT);

  logic [CW-1:0] w_m1_q, w_m1_d;
  logic [HW-1:0] h_q, h_d;
  logic [RW-1:0] h_m1_q, h_m1_d;
  logic [HW-1:0] in_row_q, in_row_d;
  logic [CW-1:0] in_col_q, in_col_d;
  logic [RW-1:0] em_row_q, em_row_d;
  logic [CW-1:0] em_col_q, em_col_d;
  pix_t          first_pix_q;

  logic    pix_take, fl_take, pix_emit, frame_end;
  item_t   item;

  always_comb begin
    pix_take = (kind_i == KIND_PIXEL) && (in_row_q < h_q);
    fl_take  = (kind_i == KIND_FLUSH) && (in_row_q >= h_q);
    // a pixel emits once it is at least one row plus one pixel into the frame
    pix_emit = (in_row_q >= HW'(2)) || ((in_row_q == HW'(1)) && (in_col_q != '0));

    item.border.top   = (em_row_q == '0);
    item.border.bot   = (em_row_q == h_m1_q);
    item.border.left  = (em_col_q == '0);
    item.border.right = (em_col_q == w_m1_q);
    item.take  = pix_take || fl_take;
    item.emit  = fl_take || (pix_take && pix_emit);
    item.write = pix_take;
    // a one-row frame drains without the extra column a taller frame sees
    item.fix   = fl_take && (h_m1_q == '0) && (em_col_q == '0);
    frame_end  = item.border.bot && item.border.right;

    if (pix_take) addr_o = in_col_q;
    else if (item.border.right) addr_o = '0;
    else addr_o = em_col_q + 1'b1;

    pix_o = item.fix ? first_pix_q : pixel_i;
  end

  assign item_o   = item;
  assign em_row_o = em_row_q;
  assign em_col_o = em_col_q;

  always_comb begin
    w_m1_d   = w_m1_q;
    h_d      = h_q;
    h_m1_d   = h_m1_q;
    in_row_d = in_row_q;
    in_col_d = in_col_q;
    em_row_d = em_row_q;
    em_col_d = em_col_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_IMAGE_WIDTH: begin
          w_m1_d = CW'(sat_dim(32'(cfg_data_i[CFG_WIDTH_BITS-1:0]), MAX_WIDTH) - 1);
        end
        REG_IMAGE_HEIGHT: begin
          h_d    = HW'(sat_dim(32'(cfg_data_i[CFG_HEIGHT_BITS-1:0]), MAX_HEIGHT));
          h_m1_d = RW'(sat_dim(32'(cfg_data_i[CFG_HEIGHT_BITS-1:0]), MAX_HEIGHT) - 1);
        end
        default: ;
      endcase
      in_row_d = '0;
      in_col_d = '0;
      em_row_d = '0;
      em_col_d = '0;
    end else if (accept_i && item.take) begin
      if (pix_take) begin
        if (in_col_q == w_m1_q) begin
          in_col_d = '0;
          in_row_d = in_row_q + 1'b1;
        end else begin
          in_col_d = in_col_q + 1'b1;
        end
      end
      if (item.emit) begin
        if (frame_end) begin
          in_row_d = '0;
          in_col_d = '0;
          em_row_d = '0;
          em_col_d = '0;
        end else if (item.border.right) begin
          em_col_d = '0;
          em_row_d = em_row_q + 1'b1;
        end else begin
          em_col_d = em_col_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_m1_q   <= CW'(W_RST - 1);
      h_q      <= HW'(H_RST);
      h_m1_q   <= RW'(H_RST - 1);
      in_row_q <= '0;
      in_col_q <= '0;
      em_row_q <= '0;
      em_col_q <= '0;
    end else begin
      w_m1_q   <= w_m1_d;
      h_q      <= h_d;
      h_m1_q   <= h_m1_d;
      in_row_q <= in_row_d;
      in_col_q <= in_col_d;
      em_row_q <= em_row_d;
      em_col_q <= em_col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && pix_take && (in_row_q == '0) && (in_col_q == '0)) begin
      first_pix_q <= pixel_i;
    end
  end

  a_in_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_col_q <= w_m1_q)
    else $error("input column past end of row");

  a_em_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    em_col_q <= w_m1_q)
    else $error("emit column past end of row");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cfg_we_i && accept_i && item.emit && frame_end) |=>
      (in_row_q == '0) && (in_col_q == '0) && (em_row_q == '0) && (em_col_q == '0))
    else $error("counters not cleared after final code of frame");

endmodule

[hw/rtl/lbp_line_buf.sv]
// Two row stores: line_middle holds the previous row, line_above the one before.
// Registered read, read-before-write at the same column. Depends on lbp_pkg.
module lbp_line_buf #(
  parameter int unsigned MAX_WIDTH = lbp_pkg::DEF_MAX_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic                         wr_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] addr_i,
  input  lbp_pkg::pix_t                pix_i,
  output lbp_pkg::pix_t                above_o,
  output lbp_pkg::pix_t                mid_o
);
  import lbp_pkg::*;

  pix_t line_above [MAX_WIDTH];
  pix_t line_middle [MAX_WIDTH];
  pix_t above_rd_q;
  pix_t mid_rd_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      above_rd_q <= line_above[addr_i];
      mid_rd_q   <= line_middle[addr_i];
    end
    // each column moves up one row as the new pixel lands below it
    if (wr_en_i) begin
      line_above[addr_i]  <= line_middle[addr_i];
      line_middle[addr_i] <= pix_i;
    end
  end

  assign above_o = above_rd_q;
  assign mid_o   = mid_rd_q;

endmodule

[hw/rtl/lbp_code.sv]
// Column stage, 3x3 window, neighbor compare and output register with handshake.
// Depends on lbp_pkg; column taps come from lbp_line_buf.
module lbp_code #(
  parameter int unsigned MAX_WIDTH  = lbp_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = lbp_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  lbp_pkg::item_t                item_i,
  input  lbp_pkg::pix_t                 pix_i,
  input  logic [$clog2(MAX_HEIGHT)-1:0] em_row_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  em_col_i,
  input  lbp_pkg::pix_t                 col_top_i,
  input  lbp_pkg::pix_t                 col_mid_i,
  input  logic                          out_stall_i,
  output logic                          ready_o,
  output logic                          out_valid_o,
  output logic [lbp_pkg::CODE_W-1:0]    code_o,
  output logic [lbp_pkg::ROW_W-1:0]     out_row_o,
  output logic [lbp_pkg::COL_W-1:0]     out_col_o,
  output logic                          frame_last_o
);
  import lbp_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  logic          s1_valid_q, s1_valid_d;
  logic          s1_emit_q;
  logic          s1_fix_q;
  border_t       s1_border_q;
  pix_t          s1_pix_q;
  logic [RW-1:0] s1_row_q;
  logic [CW-1:0] s1_col_q;

  col_t col_a_q, col_b_q;
  col_t cur, win_b;
  pix_t ctr;
  logic [CODE_W-1:0] code;

  logic out_valid_q, out_valid_d;
  logic [CODE_W-1:0] code_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic              last_q;

  logic load, s1_move, out_ready;

  always_comb begin
    out_ready = !out_valid_q || !out_stall_i;
    s1_move   = s1_valid_q && (!s1_emit_q || out_ready);
    ready_o   = !s1_valid_q || s1_move;
    load      = accept_i && item_i.take;
  end

  // window: col_a is column-1, win_b the center column, cur column+1
  always_comb begin
    cur.top = col_top_i;
    cur.mid = col_mid_i;
    cur.bot = s1_pix_q;
    win_b   = col_b_q;
    if (s1_fix_q) win_b.mid = s1_pix_q;
    ctr = win_b.mid;

    code[7] = !s1_border_q.top && !s1_border_q.left  && (col_a_q.top > ctr);
    code[6] = !s1_border_q.top                       && (win_b.top   > ctr);
    code[5] = !s1_border_q.top && !s1_border_q.right && (cur.top     > ctr);
    code[4] = !s1_border_q.right                     && (cur.mid     > ctr);
    code[3] = !s1_border_q.bot && !s1_border_q.right && (cur.bot     > ctr);
    code[2] = !s1_border_q.bot                       && (win_b.bot   > ctr);
    code[1] = !s1_border_q.bot && !s1_border_q.left  && (col_a_q.bot > ctr);
    code[0] = !s1_border_q.left                      && (col_a_q.mid > ctr);
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (load) s1_valid_d = 1'b1;
    else if (s1_move) s1_valid_d = 1'b0;

    out_valid_d = out_valid_q;
    if (s1_move && s1_emit_q) out_valid_d = 1'b1;
    else if (out_ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_emit_q   <= item_i.emit;
      s1_fix_q    <= item_i.fix;
      s1_border_q <= item_i.border;
      s1_pix_q    <= pix_i;
      s1_row_q    <= em_row_i;
      s1_col_q    <= em_col_i;
    end
    if (s1_move) begin
      col_a_q <= win_b;
      col_b_q <= cur;
    end
    if (s1_move && s1_emit_q) begin
      code_q <= code;
      row_q  <= ROW_W'(s1_row_q);
      col_q  <= COL_W'(s1_col_q);
      last_q <= s1_border_q.bot && s1_border_q.right;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_o       = code_q;
  assign out_row_o    = row_q;
  assign out_col_o    = col_q;
  assign frame_last_o = last_q;

  a_no_s1_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && s1_valid_q) |-> s1_move)
    else $error("column stage overwritten while holding a word");

  a_no_out_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !(s1_move && s1_emit_q))
    else $error("result register overwritten while stalled");

  a_emit_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_move && s1_emit_q) |=> out_valid_q)
    else $error("emitting word did not reach the result register");

endmodule

[hw/rtl/lbp_3x3_code_stream.sv]
// Top level: 8-neighbor 3x3 local binary pattern codes over a raster pixel stream.
// Depends on lbp_pkg, lbp_ctrl, lbp_line_buf, lbp_code.
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid_i/in_stall_o | kind_i, pixel_i
//  out     | out_valid_o/out_stall_i | code_o, out_row_o, out_col_o, frame_last_o
//  cfg     | cfg_we_i              | cfg_index_i, cfg_data_i
//
// One word per clock unless the output stalls; the code that a word triggers is
// registered first with the line-buffer read, then in the result register.
// Reset loads width 640, height 480 and clears the position counters; the row
// stores are not cleared, rows outside the current frame are masked instead.
// A stalled result holds; the column stage still takes words until it holds one that emits a code.
module lbp_3x3_code_stream #(
  parameter int unsigned MAX_WIDTH  = lbp_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = lbp_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lbp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lbp_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [lbp_pkg::PIX_W-1:0]     pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lbp_pkg::CODE_W-1:0]    code_o,
  output logic [lbp_pkg::ROW_W-1:0]     out_row_o,
  output logic [lbp_pkg::COL_W-1:0]     out_col_o,
  output logic                          frame_last_o
);
  import lbp_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  logic          accept, ready;
  item_t         item;
  pix_t          pix;
  pix_t          col_top, col_mid;
  logic [CW-1:0] addr, em_col;
  logic [RW-1:0] em_row;

  assign in_stall_o = !ready;
  assign accept     = in_valid_i && ready;

  lbp_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .kind_i      (kind_i),
    .pixel_i     (pixel_i),
    .item_o      (item),
    .pix_o       (pix),
    .addr_o      (addr),
    .em_col_o    (em_col),
    .em_row_o    (em_row)
  );

  lbp_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i   (clk_i),
    .rd_en_i (accept && item.take),
    .wr_en_i (accept && item.write),
    .addr_i  (addr),
    .pix_i   (pix),
    .above_o (col_top),
    .mid_o   (col_mid)
  );

  lbp_code #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_code (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .item_i       (item),
    .pix_i        (pix),
    .em_row_i     (em_row),
    .em_col_i     (em_col),
    .col_top_i    (col_top),
    .col_mid_i    (col_mid),
    .out_stall_i  (out_stall_i),
    .ready_o      (ready),
    .out_valid_o  (out_valid_o),
    .code_o       (code_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .frame_last_o (frame_last_o)
  );

endmodule
